// ===== design/cst_pkg.sv =====
// Package: shared types, character codes and per-byte functions of the tokenizer.
`timescale 1ns / 1ps

package cst_pkg;

   // Character codes that the comment stripper looks for.
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_POUND = 8'h23;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   // Register indexes of the configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELIM_LO = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELIM_HI = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEEP_LO  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEEP_HI  = 2'd3;
   localparam int CSR_DATA_W = 64;

   // Reset value of the low delimiter mask: '#' and ';'.
   localparam logic [CSR_DATA_W-1:0] DELIM_LO_RESET = 64'd576460786663161856;

   // Result queue sizing.
   localparam int MAX_RESULTS = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

   // Comment state of the stripper.
   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_BLOCK  = 2'd1,
      MODE_LINE   = 2'd2
   } mode_type;

   // One result word.
   typedef struct packed {
      logic [7:0] tok_char;
      logic       tok_begin;
      logic       stream_end;
   } word_type;

   // Outcome of judging one byte against its lookahead.
   typedef struct packed {
      logic [7:0] ch;
      logic       eat;
      mode_type   mode;
   } clean_type;

   // Outcome of passing one cleaned character through the splitter.
   typedef struct packed {
      logic emit;
      logic first;
      logic in_token;
   } split_type;

   // Decide what byte h becomes given lookahead nx; eat marks nx as part of a marker.
   function automatic clean_type clean_byte(mode_type mode, logic [7:0] h, logic consumed,
                                            logic [7:0] nx);
      clean_type r;
      r.ch   = h;
      r.eat  = 1'b0;
      r.mode = mode;
      if (consumed) begin
         r.ch = CHAR_SPACE;
      end else begin
         case (mode)
            MODE_BLOCK: begin
               r.ch = CHAR_SPACE;
               if (h == CHAR_STAR && nx == CHAR_SLASH) begin
                  r.eat  = 1'b1;
                  r.mode = MODE_NORMAL;
               end
            end
            MODE_LINE: begin
               if (h == CHAR_LF || h == CHAR_CR) begin
                  r.mode = MODE_NORMAL;
               end else begin
                  r.ch = CHAR_SPACE;
               end
            end
            default: begin
               if (h == CHAR_SLASH && nx == CHAR_STAR) begin
                  r.ch   = CHAR_SPACE;
                  r.eat  = 1'b1;
                  r.mode = MODE_BLOCK;
               end else if (h == CHAR_SLASH && nx == CHAR_SLASH) begin
                  r.ch   = CHAR_SPACE;
                  r.eat  = 1'b1;
                  r.mode = MODE_LINE;
               end else if (h == CHAR_POUND) begin
                  r.ch   = CHAR_SPACE;
                  r.mode = MODE_LINE;
               end
            end
         endcase
      end
      return r;
   endfunction

   // Split at whitespace and delimiters; kept delimiters become one-character tokens.
   function automatic split_type split_char(logic [7:0] c, logic in_token,
                                            logic [2*CSR_DATA_W-1:0] delim,
                                            logic [2*CSR_DATA_W-1:0] keep);
      split_type r;
      logic      is_del;
      logic      is_ws;
      is_del = !c[7] && delim[c[6:0]];
      is_ws  = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
      if (is_del || is_ws) begin
         r.in_token = 1'b0;
         r.emit     = is_del && keep[c[6:0]];
         r.first    = 1'b1;
      end else begin
         r.in_token = 1'b1;
         r.emit     = 1'b1;
         r.first    = !in_token;
      end
      return r;
   endfunction

endpackage

// ===== design/cst_req_if.sv =====
// Interface: input byte channel of the tokenizer.
`timescale 1ns / 1ps

interface cst_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== design/cst_rsp_if.sv =====
// Interface: result word channel of the tokenizer.
`timescale 1ns / 1ps

interface cst_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tok_char;
   logic       tok_begin;
   logic       stream_end;

   modport source (output valid, output tok_char, output tok_begin, output stream_end,
                   input ready);
   modport sink (input valid, input tok_char, input tok_begin, input stream_end,
                 output ready);
endinterface

// ===== design/comment_stripping_tokenizer_unit.sv =====
// Top level: comment-stripping tokenizer with a four-word result queue.
`timescale 1ns / 1ps

// Takes a text file one byte per word on req_bus and returns token characters on
// rsp_bus, each flagged when it opens a token, followed by one end-marker word after
// the byte marked last. Block, line and pound comments turn into spaces; the byte is
// judged one byte late, using the next byte as lookahead. One byte is accepted per
// clock: the work for a byte is combinational, and its results (zero to three words) go
// into a four-word queue that drains one word per cycle while rsp_bus is ready. A byte
// is accepted only while the queue, after this cycle's drain, has room for three words.
// A byte that is not the last of its file makes at most one word, so only the last byte
// of a file, which can make up to three, can slow intake to the output rate.
// Configuration writes take effect on the next clock and are meant for idle periods only.

module comment_stripping_tokenizer_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   cst_req_if.sink                               req_bus,
   cst_rsp_if.source                             rsp_bus,
   input  logic                                  csr_write,
   input  logic [cst_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [cst_pkg::CSR_DATA_W-1:0]        csr_data
);

   // Configuration registers.
   logic [cst_pkg::CSR_DATA_W-1:0] delim_lo_ff, delim_hi_ff, keep_lo_ff, keep_hi_ff;

   // Lexer state.
   cst_pkg::mode_type mode_ff, mode_in;
   logic [7:0]        held_byte_ff, held_byte_in;
   logic              held_valid_ff, held_valid_in;
   logic              held_consumed_ff, held_consumed_in;
   logic              in_token_ff, in_token_in;

   // Result queue, head at slot zero.
   cst_pkg::word_type               queue_ff [cst_pkg::QUEUE_DEPTH];
   cst_pkg::word_type               queue_in [cst_pkg::QUEUE_DEPTH];
   logic [cst_pkg::QCOUNT_W-1:0]    count_ff, count_in;

   logic                            accept;
   logic                            pop;
   logic [cst_pkg::QCOUNT_W-1:0]    avail;

   // Per-byte results.
   cst_pkg::clean_type clean_held, clean_last;
   cst_pkg::split_type split_held, split_last;
   cst_pkg::mode_type  mode_mid;
   logic               token_mid;
   logic               consumed_mid;
   cst_pkg::word_type  word0, word1, word2;
   logic               push0, push1, push2;
   logic [cst_pkg::QCOUNT_W-1:0] pos0, pos1, pos2;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         delim_lo_ff <= cst_pkg::DELIM_LO_RESET;
         delim_hi_ff <= '0;
         keep_lo_ff  <= '0;
         keep_hi_ff  <= '0;
      end else if (csr_write) begin
         case (csr_index)
            cst_pkg::CSR_DELIM_LO: delim_lo_ff <= csr_data;
            cst_pkg::CSR_DELIM_HI: delim_hi_ff <= csr_data;
            cst_pkg::CSR_KEEP_LO:  keep_lo_ff  <= csr_data;
            cst_pkg::CSR_KEEP_HI:  keep_hi_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // Handshakes: intake needs room for a full set of words after this cycle's drain.
   assign pop           = rsp_bus.valid && rsp_bus.ready;
   assign avail         = count_ff - cst_pkg::QCOUNT_W'(pop);
   assign req_bus.ready = avail <= cst_pkg::QCOUNT_W'(cst_pkg::QUEUE_DEPTH -
                                                      cst_pkg::MAX_RESULTS);
   assign accept        = req_bus.valid && req_bus.ready;

   // Judge the held byte against the new one, then the new byte itself if it is last.
   always_comb begin
      clean_held   = cst_pkg::clean_byte(mode_ff, held_byte_ff, held_consumed_ff,
                                         req_bus.in_byte);
      split_held   = cst_pkg::split_char(clean_held.ch, in_token_ff,
                                         {delim_hi_ff, delim_lo_ff},
                                         {keep_hi_ff, keep_lo_ff});
      mode_mid     = held_valid_ff ? clean_held.mode : mode_ff;
      token_mid    = held_valid_ff ? split_held.in_token : in_token_ff;
      consumed_mid = held_valid_ff && clean_held.eat;

      clean_last   = cst_pkg::clean_byte(mode_mid, req_bus.in_byte, consumed_mid,
                                         cst_pkg::CHAR_NUL);
      split_last   = cst_pkg::split_char(clean_last.ch, token_mid,
                                         {delim_hi_ff, delim_lo_ff},
                                         {keep_hi_ff, keep_lo_ff});

      word0 = '{tok_char: clean_held.ch, tok_begin: split_held.first, stream_end: 1'b0};
      word1 = '{tok_char: clean_last.ch, tok_begin: split_last.first, stream_end: 1'b0};
      word2 = '{tok_char: cst_pkg::CHAR_NUL, tok_begin: 1'b0, stream_end: 1'b1};
      push0 = accept && held_valid_ff && split_held.emit;
      push1 = accept && req_bus.in_last && split_last.emit;
      push2 = accept && req_bus.in_last;
      pos0  = avail;
      pos1  = avail + cst_pkg::QCOUNT_W'(push0);
      pos2  = pos1 + cst_pkg::QCOUNT_W'(push1);
   end

   // Next lexer state; the end of a file returns everything but the registers to reset.
   always_comb begin
      mode_in          = mode_ff;
      held_byte_in     = held_byte_ff;
      held_valid_in    = held_valid_ff;
      held_consumed_in = held_consumed_ff;
      in_token_in      = in_token_ff;
      if (accept) begin
         if (req_bus.in_last) begin
            mode_in          = cst_pkg::MODE_NORMAL;
            held_byte_in     = cst_pkg::CHAR_NUL;
            held_valid_in    = 1'b0;
            held_consumed_in = 1'b0;
            in_token_in      = 1'b0;
         end else begin
            mode_in          = mode_mid;
            held_byte_in     = req_bus.in_byte;
            held_valid_in    = 1'b1;
            held_consumed_in = consumed_mid;
            in_token_in      = token_mid;
         end
      end
   end

   // Queue update: shift on drain, then append the new words behind what remains.
   always_comb begin
      for (int i = 0; i < cst_pkg::QUEUE_DEPTH; i++) begin
         if (pop && i < cst_pkg::QUEUE_DEPTH - 1) begin
            queue_in[i] = queue_ff[i+1];
         end else begin
            queue_in[i] = queue_ff[i];
         end
         if (push0 && pos0 == cst_pkg::QCOUNT_W'(i)) begin
            queue_in[i] = word0;
         end
         if (push1 && pos1 == cst_pkg::QCOUNT_W'(i)) begin
            queue_in[i] = word1;
         end
         if (push2 && pos2 == cst_pkg::QCOUNT_W'(i)) begin
            queue_in[i] = word2;
         end
      end
      count_in = avail + cst_pkg::QCOUNT_W'(push0) + cst_pkg::QCOUNT_W'(push1)
               + cst_pkg::QCOUNT_W'(push2);
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= cst_pkg::MODE_NORMAL;
         held_valid_ff    <= 1'b0;
         held_consumed_ff <= 1'b0;
         in_token_ff      <= 1'b0;
         held_byte_ff     <= cst_pkg::CHAR_NUL;
         count_ff         <= '0;
      end else begin
         mode_ff          <= mode_in;
         held_valid_ff    <= held_valid_in;
         held_consumed_ff <= held_consumed_in;
         in_token_ff      <= in_token_in;
         held_byte_ff     <= held_byte_in;
         count_ff         <= count_in;
      end
   end

   // Queue payload needs no reset.
   always_ff @(posedge clock) begin
      queue_ff <= queue_in;
   end

   // Head of the queue drives the result channel.
   assign rsp_bus.valid      = count_ff != '0;
   assign rsp_bus.tok_char   = queue_ff[0].tok_char;
   assign rsp_bus.tok_begin  = queue_ff[0].tok_begin;
   assign rsp_bus.stream_end = queue_ff[0].stream_end;

endmodule

// ===== verif/tb.sv =====
// Testbench for the tokenizer: directed table, then random files checked against a model.
`timescale 1ns / 1ps

module tb;

   localparam int HALF_PERIOD  = 4;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_BYTES  = 30;
   localparam int TIMEOUT_NS   = 2_000_000;
   localparam cst_pkg::word_type NO_WORD = '0;

   // One row of the directed table; typed rows carry their own result words.
   typedef struct packed {
      logic [7:0]        data;
      logic              is_last;
      logic              load_keep;
      logic              typed;
      logic [1:0]        typed_n;
      cst_pkg::word_type w0;
      cst_pkg::word_type w1;
      cst_pkg::word_type w2;
   } script_row_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            csr_write;
   logic [cst_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [cst_pkg::CSR_DATA_W-1:0]  csr_data;

   cst_req_if req_bus ();
   cst_rsp_if rsp_bus ();

   comment_stripping_tokenizer_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Lexer model state and its copy of the mask registers.
   cst_pkg::mode_type lex_mode;
   logic [7:0]        held_char;
   logic              held_ok;
   logic              held_eaten;
   logic              tok_open;
   logic [63:0]       delim_lo;
   logic [63:0]       delim_hi;
   logic [63:0]       keep_lo;
   logic [63:0]       keep_hi;

   cst_pkg::word_type step_words[3];
   int                step_count;
   cst_pkg::word_type token_backlog[$];
   logic [7:0]        file_bytes[$];
   script_row_type    script[25];
   string             punct_set = ";(),{}[]=:.-+<>*/";

   int mismatch_count = 0;
   int words_checked  = 0;
   int bytes_sent     = 0;
   int files_sent     = 0;
   int mask_settings  = 0;
   int tx_idle_pct    = 0;
   int rx_stall_pct   = 0;
   int stall_pending  = 0;
   int stall_left     = 0;

   always #HALF_PERIOD clock = ~clock;

   // Append one byte to the file being built.
   function automatic void add_byte(input logic [7:0] b);
      file_bytes.insert(file_bytes.size(), b);
   endfunction

   // Append one word to the list of words still owed by the block.
   function automatic void owe_word(input cst_pkg::word_type w);
      token_backlog.insert(token_backlog.size(), w);
   endfunction

   // Return the mask bit of a character; codes 128 and up never hit.
   function automatic logic mask_hit(input logic [63:0] lo, input logic [63:0] hi,
                                     input logic [7:0] c);
      if (c[7]) return 1'b0;
      return c[6] ? hi[c[5:0]] : lo[c[5:0]];
   endfunction

   // Turn the held byte into its cleaned form using the lookahead; tracks comment mode.
   function automatic logic [7:0] judge_held(input logic [7:0] h, input logic eaten,
                                             input logic [7:0] nx, output logic eat);
      eat = 1'b0;
      if (eaten) return cst_pkg::CHAR_SPACE;
      case (lex_mode)
         cst_pkg::MODE_BLOCK: begin
            if (h == cst_pkg::CHAR_STAR && nx == cst_pkg::CHAR_SLASH) begin
               eat = 1'b1;
               lex_mode = cst_pkg::MODE_NORMAL;
            end
            return cst_pkg::CHAR_SPACE;
         end
         cst_pkg::MODE_LINE: begin
            if (h == cst_pkg::CHAR_LF || h == cst_pkg::CHAR_CR) begin
               lex_mode = cst_pkg::MODE_NORMAL;
               return h;
            end
            return cst_pkg::CHAR_SPACE;
         end
         default: begin
            if (h == cst_pkg::CHAR_SLASH && nx == cst_pkg::CHAR_STAR) begin
               eat = 1'b1;
               lex_mode = cst_pkg::MODE_BLOCK;
               return cst_pkg::CHAR_SPACE;
            end
            if (h == cst_pkg::CHAR_SLASH && nx == cst_pkg::CHAR_SLASH) begin
               eat = 1'b1;
               lex_mode = cst_pkg::MODE_LINE;
               return cst_pkg::CHAR_SPACE;
            end
            if (h == cst_pkg::CHAR_POUND) begin
               lex_mode = cst_pkg::MODE_LINE;
               return cst_pkg::CHAR_SPACE;
            end
            return h;
         end
      endcase
   endfunction

   // Split a cleaned character into token words.
   function automatic void split_emit(input logic [7:0] c);
      logic is_del;
      logic is_ws;
      is_del = mask_hit(delim_lo, delim_hi, c);
      is_ws  = (c == cst_pkg::CHAR_SPACE) ||
               (c >= cst_pkg::CHAR_TAB && c <= cst_pkg::CHAR_CR);
      if (is_del || is_ws) begin
         tok_open = 1'b0;
         if (is_del && mask_hit(keep_lo, keep_hi, c)) begin
            step_words[step_count] = '{c, 1'b1, 1'b0};
            step_count++;
         end
      end else begin
         step_words[step_count] = '{c, !tok_open, 1'b0};
         step_count++;
         tok_open = 1'b1;
      end
   endfunction

   function automatic void clear_lexer();
      lex_mode   = cst_pkg::MODE_NORMAL;
      held_char  = 8'h00;
      held_ok    = 1'b0;
      held_eaten = 1'b0;
      tok_open   = 1'b0;
   endfunction

   // Work out the words that one accepted byte produces.
   function automatic void strip_and_split(input logic [7:0] b, input logic is_last);
      logic       eat;
      logic [7:0] c;
      step_count = 0;
      if (held_ok) begin
         c = judge_held(held_char, held_eaten, b, eat);
         split_emit(c);
         held_eaten = eat;
      end else begin
         held_eaten = 1'b0;
      end
      held_char = b;
      held_ok   = 1'b1;
      if (is_last) begin
         c = judge_held(held_char, held_eaten, cst_pkg::CHAR_NUL, eat);
         split_emit(c);
         step_words[step_count] = '{cst_pkg::CHAR_NUL, 1'b0, 1'b1};
         step_count++;
         clear_lexer();
      end
   endfunction

   // Random filler for comment bodies, biased toward marker characters.
   function automatic logic [7:0] comment_char();
      case ($urandom_range(0, 7))
         0: return cst_pkg::CHAR_STAR;
         1: return cst_pkg::CHAR_SLASH;
         2: return cst_pkg::CHAR_POUND;
         3: return cst_pkg::CHAR_SPACE;
         4: return 8'($urandom_range(0, 255));
         default: return 8'(8'h61 + $urandom_range(0, 25));
      endcase
   endfunction

   // Build one random file, mostly well-formed text with some noise.
   task automatic build_file();
      int target;
      file_bytes.delete();
      target = $urandom_range(4, 40);
      while (file_bytes.size() < target) begin
         case ($urandom_range(0, 15))
            0, 1, 2, 3, 4, 15: begin
               repeat ($urandom_range(1, 6)) begin
                  if ($urandom_range(0, 3) == 0)
                     add_byte(8'(8'h30 + $urandom_range(0, 9)));
                  else
                     add_byte(8'(8'h61 + $urandom_range(0, 25)));
               end
            end
            5, 6: begin
               if ($urandom_range(0, 1) == 1) add_byte(cst_pkg::CHAR_SPACE);
               else add_byte(8'($urandom_range(9, 13)));
            end
            7, 8: begin
               add_byte(punct_set[$urandom_range(0, punct_set.len() - 1)]);
            end
            9: begin
               add_byte(cst_pkg::CHAR_SLASH);
               add_byte(cst_pkg::CHAR_STAR);
               repeat ($urandom_range(0, 8)) add_byte(comment_char());
               // Now and then the block comment is left open.
               if ($urandom_range(0, 9) != 0) begin
                  add_byte(cst_pkg::CHAR_STAR);
                  add_byte(cst_pkg::CHAR_SLASH);
               end
            end
            10, 11: begin
               if ($urandom_range(0, 1) == 1) begin
                  add_byte(cst_pkg::CHAR_SLASH);
                  add_byte(cst_pkg::CHAR_SLASH);
               end else begin
                  add_byte(cst_pkg::CHAR_POUND);
               end
               repeat ($urandom_range(0, 8)) add_byte(comment_char());
               add_byte(($urandom_range(0, 1) == 1) ? cst_pkg::CHAR_LF : cst_pkg::CHAR_CR);
            end
            12: begin
               repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
            end
            13: begin
               add_byte(8'($urandom_range(128, 255)));
            end
            default: begin
               // Loose marker characters that may or may not pair up.
               repeat ($urandom_range(2, 4)) begin
                  case ($urandom_range(0, 3))
                     0: add_byte(cst_pkg::CHAR_SLASH);
                     1: add_byte(cst_pkg::CHAR_STAR);
                     2: add_byte(cst_pkg::CHAR_POUND);
                     default: add_byte(cst_pkg::CHAR_LF);
                  endcase
               end
            end
         endcase
      end
   endtask

   // Offer one byte, with random idle cycles first, and record its words once accepted.
   task automatic send_byte(input script_row_type r);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.in_byte <= r.data;
      req_bus.in_last <= r.is_last;
      do @(posedge clock); while (!req_bus.ready);
      strip_and_split(r.data, r.is_last);
      if (r.typed) begin
         if (r.typed_n > 2'd0) owe_word(r.w0);
         if (r.typed_n > 2'd1) owe_word(r.w1);
         if (r.typed_n > 2'd2) owe_word(r.w2);
      end else begin
         for (int i = 0; i < step_count; i++) owe_word(step_words[i]);
      end
      bytes_sent++;
      if (r.is_last) files_sent++;
   endtask

   // Wait until every word has come back, then let the pipeline settle.
   task automatic wait_idle();
      while (token_backlog.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [cst_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [63:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      case (idx)
         cst_pkg::CSR_DELIM_LO: delim_lo = value;
         cst_pkg::CSR_DELIM_HI: delim_hi = value;
         cst_pkg::CSR_KEEP_LO:  keep_lo  = value;
         cst_pkg::CSR_KEEP_HI:  keep_hi  = value;
         default: ;
      endcase
   endtask

   // Write all four masks on consecutive clocks; the enable drops once at the end.
   task automatic write_masks(input logic [63:0] dlo, input logic [63:0] dhi,
                              input logic [63:0] klo, input logic [63:0] khi);
      write_reg(cst_pkg::CSR_DELIM_LO, dlo);
      write_reg(cst_pkg::CSR_DELIM_HI, dhi);
      write_reg(cst_pkg::CSR_KEEP_LO, klo);
      write_reg(cst_pkg::CSR_KEEP_HI, khi);
      csr_write <= 1'b0;
   endtask

   // One mask setting with one traffic pattern, fed whole random files.
   task automatic run_phase(input logic [63:0] dlo, input logic [63:0] dhi,
                            input logic [63:0] klo, input logic [63:0] khi,
                            input int tx_pct, input int rx_pct, input int hold);
      int             sent;
      script_row_type r;
      write_masks(dlo, dhi, klo, khi);
      tx_idle_pct   = tx_pct;
      rx_stall_pct  = rx_pct;
      stall_pending = hold;
      sent = 0;
      while (sent < PHASE_BYTES) begin
         build_file();
         foreach (file_bytes[i]) begin
            r = '{file_bytes[i], (i == file_bytes.size() - 1), 1'b0, 1'b0, 2'd0,
                  NO_WORD, NO_WORD, NO_WORD};
            send_byte(r);
            sent++;
         end
      end
      req_bus.valid <= 1'b0;
      wait_idle();
      mask_settings++;
   endtask

   // Result side: random stalls, plus a long hold-off counted here when requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else if (stall_pending > 0) begin
         stall_left    = stall_pending - 1;
         stall_pending = 0;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // Compare each accepted word with the oldest one still owed.
   always @(posedge clock) begin : word_check
      cst_pkg::word_type got_word;
      cst_pkg::word_type want_word;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got_word = '{rsp_bus.tok_char, rsp_bus.tok_begin, rsp_bus.stream_end};
         if (token_backlog.size() == 0) begin
            $display("%0t: word with none owed: char %h begin %b end %b", $time,
                     got_word.tok_char, got_word.tok_begin, got_word.stream_end);
            mismatch_count++;
         end else begin
            want_word = token_backlog.pop_front();
            words_checked++;
            if (got_word.tok_char !== want_word.tok_char) begin
               $display("%0t: tok_char expected %h actual %h", $time,
                        want_word.tok_char, got_word.tok_char);
               mismatch_count++;
            end
            if (got_word.tok_begin !== want_word.tok_begin) begin
               $display("%0t: tok_begin expected %b actual %b", $time,
                        want_word.tok_begin, got_word.tok_begin);
               mismatch_count++;
            end
            if (got_word.stream_end !== want_word.stream_end) begin
               $display("%0t: stream_end expected %b actual %b", $time,
                        want_word.stream_end, got_word.stream_end);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #TIMEOUT_NS;
      $display("comment_stripping_tokenizer_unit verification failed");
      $finish;
   end

   initial begin
      reset           = 1'b1;
      csr_write       = 1'b0;
      csr_index       = cst_pkg::CSR_DELIM_LO;
      csr_data        = '0;
      req_bus.valid   = 1'b0;
      req_bus.in_byte = 8'h00;
      req_bus.in_last = 1'b0;
      delim_lo = cst_pkg::DELIM_LO_RESET;
      delim_hi = '0;
      keep_lo  = '0;
      keep_hi  = '0;
      clear_lexer();

      // Directed text under the reset masks: a token, block, line and pound comments.
      script[0]  = '{8'h61, 1'b0, 1'b0, 1'b1, 2'd0, NO_WORD, NO_WORD, NO_WORD};
      script[1]  = '{8'h62, 1'b0, 1'b0, 1'b1, 2'd1, '{8'h61, 1'b1, 1'b0}, NO_WORD, NO_WORD};
      script[2]  = '{8'h3B, 1'b0, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD, NO_WORD};
      script[3]  = '{cst_pkg::CHAR_SLASH, 1'b0, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD, NO_WORD};
      script[4]  = '{cst_pkg::CHAR_STAR, 1'b0, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD, NO_WORD};
      script[5]  = '{8'h78, 1'b0, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD, NO_WORD};
      script[6]  = '{cst_pkg::CHAR_STAR, 1'b0, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD, NO_WORD};
      script[7]  = '{cst_pkg::CHAR_SLASH, 1'b0, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD, NO_WORD};
      script[8]  = '{8'h64, 1'b0, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD, NO_WORD};
      script[9]  = '{cst_pkg::CHAR_SLASH, 1'b0, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD, NO_WORD};
      script[10] = '{cst_pkg::CHAR_SLASH, 1'b0, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD, NO_WORD};
      script[11] = '{8'h71, 1'b0, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD, NO_WORD};
      script[12] = '{cst_pkg::CHAR_LF, 1'b0, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD, NO_WORD};
      script[13] = '{cst_pkg::CHAR_POUND, 1'b0, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD, NO_WORD};
      script[14] = '{8'h7A, 1'b0, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD, NO_WORD};
      script[15] = '{cst_pkg::CHAR_CR, 1'b0, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD, NO_WORD};
      // A zero byte and high bytes are ordinary characters; the file ends on a high byte.
      script[16] = '{cst_pkg::CHAR_NUL, 1'b0, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD, NO_WORD};
      script[17] = '{8'hFF, 1'b0, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD, NO_WORD};
      script[18] = '{8'h80, 1'b1, 1'b0, 1'b1, 2'd3, '{8'hFF, 1'b0, 1'b0},
                     '{8'h80, 1'b0, 1'b0}, '{cst_pkg::CHAR_NUL, 1'b0, 1'b1}};
      // A one-byte file, then a file that is nothing but an open block comment.
      script[19] = '{cst_pkg::CHAR_SLASH, 1'b1, 1'b0, 1'b1, 2'd2,
                     '{cst_pkg::CHAR_SLASH, 1'b1, 1'b0},
                     '{cst_pkg::CHAR_NUL, 1'b0, 1'b1}, NO_WORD};
      script[20] = '{cst_pkg::CHAR_SLASH, 1'b0, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD, NO_WORD};
      script[21] = '{cst_pkg::CHAR_STAR, 1'b1, 1'b0, 1'b1, 2'd1,
                     '{cst_pkg::CHAR_NUL, 1'b0, 1'b1}, NO_WORD, NO_WORD};
      // Semicolon kept as a token; the keep bit of 'k' has no delimiter bit behind it.
      script[22] = '{8'h6B, 1'b0, 1'b1, 1'b0, 2'd0, NO_WORD, NO_WORD, NO_WORD};
      script[23] = '{8'h3B, 1'b0, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD, NO_WORD};
      script[24] = '{8'h6B, 1'b1, 1'b0, 1'b1, 2'd3, '{8'h3B, 1'b1, 1'b0},
                     '{8'h6B, 1'b1, 1'b0}, '{cst_pkg::CHAR_NUL, 1'b0, 1'b1}};

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].load_keep) begin
            req_bus.valid <= 1'b0;
            wait_idle();
            // Keep bit 59 is ';', high keep bit 43 is 'k'.
            write_masks(cst_pkg::DELIM_LO_RESET, '0, 64'd1 << 59, 64'd1 << 43);
            mask_settings++;
         end
         send_byte(script[i]);
      end
      req_bus.valid <= 1'b0;
      wait_idle();

      // Random files over a spread of mask settings and traffic patterns.
      run_phase(cst_pkg::DELIM_LO_RESET, '0, '0, '0, 0, 0, 0);
      run_phase('1, '1, '0, '0, 49, 0, 0);
      run_phase('1, '1, '1, '1, 0, 49, 120);
      run_phase('0, '0, '0, '0, 32, 32, 0);
      run_phase({$urandom, $urandom}, {$urandom, $urandom}, '1, '1, 0, 0, 0);
      run_phase(cst_pkg::DELIM_LO_RESET | {$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom} & {$urandom, $urandom}, {$urandom, $urandom}, 49, 0, 0);
      run_phase({$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom}, {$urandom, $urandom}, 0, 49, 0);
      run_phase({$urandom, $urandom}, '0, {$urandom, $urandom}, '1, 32, 32, 60);

      $display("Run covered %0d files, %0d bytes in and %0d token words checked.",
               files_sent, bytes_sent, words_checked);
      $display("Traffic ran over %0d mask settings, with idle, stalled and held-off phases.",
               mask_settings);
      if (mismatch_count == 0) begin
         $display("comment_stripping_tokenizer_unit verification clean");
      end else begin
         $display("comment_stripping_tokenizer_unit verification failed");
      end
      $finish;
   end

endmodule
